// ===== rtl/core/mbsp_pkg.sv =====
// ============================================================================
// mbsp_pkg
// Shared types and constants of the MIDI byte stream parser.
// ============================================================================
`default_nettype none

package mbsp_pkg;

    // Depth of the queue that separates the front and back parts.
    localparam int QDEPTH = 2;
    localparam int QPTR_W = $clog2(QDEPTH);
    localparam int QCNT_W = $clog2(QDEPTH + 1);

    // Byte classes and codes used by the parser.
    localparam logic [4:0] RT_PREFIX      = 5'b11111;  // 0xF8-0xFF
    localparam logic [5:0] SOLO_PREFIX    = 6'b111101; // 0xF4-0xF7
    localparam logic [7:0] ST_EOX         = 8'hF7;
    localparam logic [7:0] ST_SONG_POS    = 8'hF2;
    localparam logic [7:0] ST_TIME_CODE   = 8'hF1;
    localparam logic [7:0] ST_SONG_SEL    = 8'hF3;
    localparam logic [7:0] ST_SYSEX       = 8'hF0;
    localparam logic [3:0] HI_PROG_CHANGE = 4'hC;
    localparam logic [3:0] HI_CHAN_PRESS  = 4'hD;
    localparam logic [3:0] HI_PITCH_BEND  = 4'hE;
    localparam logic [3:0] HI_NOTE_OFF    = 4'h8;
    localparam logic [3:0] HI_NOTE_ON     = 4'h9;
    localparam logic [3:0] HI_POLY_PRESS  = 4'hA;
    localparam logic [3:0] HI_CTRL_CHANGE = 4'hB;

    // Message lengths.
    localparam logic [1:0] LEN_ONE   = 2'd1;
    localparam logic [1:0] LEN_TWO   = 2'd2;
    localparam logic [1:0] LEN_THREE = 2'd3;

    typedef enum logic [1:0] {
        KIND_REALTIME,
        KIND_STATUS,
        KIND_DATA
    } kind_t;

    // One classified item as it waits in the queue.
    typedef struct packed {
        kind_t       kind;
        logic        solo;     // status 0xF4-0xF6, emitted alone
        logic [7:0]  rx_byte;
        logic [15:0] stamp;
    } entry_t;

    // One completed message.
    typedef struct packed {
        logic [7:0]  status;
        logic [6:0]  data1;
        logic [6:0]  data2;
        logic [1:0]  length;
        logic [15:0] stamp;
    } msg_t;

endpackage

`default_nettype wire

// ===== rtl/core/mbsp_if.sv =====
// ============================================================================
// mbsp_if
// Channel interfaces: timestamped input bytes and completed messages.
// ============================================================================
`default_nettype none

interface mbsp_byte_if;
    logic        valid;
    logic        ready;
    logic [15:0] stamp;
    logic [7:0]  rx_byte;

    modport source (output valid, output stamp, output rx_byte, input ready);
    modport sink   (input valid, input stamp, input rx_byte, output ready);
endinterface

interface mbsp_msg_if;
    logic        valid;
    logic        ready;
    logic [7:0]  msg_status;
    logic [6:0]  msg_data1;
    logic [6:0]  msg_data2;
    logic [1:0]  msg_length;
    logic [15:0] msg_stamp;

    modport source (output valid, output msg_status, output msg_data1,
                    output msg_data2, output msg_length, output msg_stamp,
                    input ready);
    modport sink   (input valid, input msg_status, input msg_data1,
                    input msg_data2, input msg_length, input msg_stamp,
                    output ready);
endinterface

`default_nettype wire

// ===== rtl/core/mbsp_front.sv =====
// ============================================================================
// mbsp_front
// Accepts input bytes and classifies them into queue entries.
// ============================================================================
`default_nettype none

module mbsp_front (
    mbsp_byte_if.sink        byte_in,
    input  wire logic        q_full,
    output mbsp_pkg::entry_t q_wdata,
    output logic             q_push
);

    // An item is taken whenever the queue has room.
    assign byte_in.ready = !q_full;
    assign q_push        = byte_in.valid && !q_full;

    // Classify the byte: real-time, other status, or data.
    always_comb
    begin
        q_wdata.rx_byte = byte_in.rx_byte;
        q_wdata.stamp   = byte_in.stamp;
        q_wdata.solo    = (byte_in.rx_byte[7:2] == mbsp_pkg::SOLO_PREFIX)
                          && (byte_in.rx_byte != mbsp_pkg::ST_EOX);
        if (byte_in.rx_byte[7:3] == mbsp_pkg::RT_PREFIX)
        begin
            q_wdata.kind = mbsp_pkg::KIND_REALTIME;
        end
        else if (byte_in.rx_byte[7])
        begin
            q_wdata.kind = mbsp_pkg::KIND_STATUS;
        end
        else
        begin
            q_wdata.kind = mbsp_pkg::KIND_DATA;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mbsp_queue.sv =====
// ============================================================================
// mbsp_queue
// Small FIFO of classified items between the front and back parts.
// ============================================================================
`default_nettype none

module mbsp_queue (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             push,
    input  wire mbsp_pkg::entry_t wdata,
    output logic                  full,
    input  wire logic             pop,
    output logic                  not_empty,
    output mbsp_pkg::entry_t      rdata
);

    mbsp_pkg::entry_t                 slot_reg [mbsp_pkg::QDEPTH];
    logic [mbsp_pkg::QPTR_W-1:0]      wr_ptr_reg;
    logic [mbsp_pkg::QPTR_W-1:0]      rd_ptr_reg;
    logic [mbsp_pkg::QCNT_W-1:0]      count_reg;
    logic [mbsp_pkg::QCNT_W-1:0]      count_next;

    assign full      = (count_reg == mbsp_pkg::QCNT_W'(mbsp_pkg::QDEPTH));
    assign not_empty = (count_reg != '0);
    assign rdata     = slot_reg[rd_ptr_reg];

    // Occupancy follows pushes and pops.
    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    // Pointers and count.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= (wr_ptr_reg == mbsp_pkg::QPTR_W'(mbsp_pkg::QDEPTH - 1))
                              ? '0 : wr_ptr_reg + 1'b1;
            end
            if (pop)
            begin
                rd_ptr_reg <= (rd_ptr_reg == mbsp_pkg::QPTR_W'(mbsp_pkg::QDEPTH - 1))
                              ? '0 : rd_ptr_reg + 1'b1;
            end
        end
    end

    // Entry storage.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wdata;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mbsp_back.sv =====
// ============================================================================
// mbsp_back
// Applies running status to queued items and registers completed messages.
// ============================================================================
`default_nettype none

module mbsp_back (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             q_not_empty,
    input  wire mbsp_pkg::entry_t q_rdata,
    output logic                  q_pop,
    mbsp_msg_if.source            msg_out
);

    logic [7:0]     running_stat_reg, running_stat_next;
    logic           await_third_reg,  await_third_next;
    logic           msg_open_reg,     msg_open_next;
    logic [15:0]    open_stamp_reg,   open_stamp_next;
    logic [7:0]     held_status_reg,  held_status_next;
    logic [6:0]     held_data1_reg,   held_data1_next;
    logic           out_valid_reg,    out_valid_next;
    mbsp_pkg::msg_t out_msg_reg,      out_msg_next;

    logic           emit;
    logic [15:0]    mts;
    logic [3:0]     rs_hi;

    // An item is taken whenever the output register is free or draining.
    assign q_pop = q_not_empty && (!out_valid_reg || msg_out.ready);

    assign rs_hi = running_stat_reg[7:4];
    assign mts   = msg_open_reg ? open_stamp_reg : q_rdata.stamp;

    // Parser state update for the item at the head of the queue.
    always_comb
    begin
        running_stat_next = running_stat_reg;
        await_third_next  = await_third_reg;
        msg_open_next     = msg_open_reg;
        open_stamp_next   = open_stamp_reg;
        held_status_next  = held_status_reg;
        held_data1_next   = held_data1_reg;
        emit              = 1'b0;
        out_msg_next      = '{status: q_rdata.rx_byte, data1: '0, data2: '0,
                              length: mbsp_pkg::LEN_ONE, stamp: mts};

        if (q_pop)
        begin
            if (q_rdata.kind == mbsp_pkg::KIND_REALTIME)
            begin
                // Real-time byte: passes through and may advance the stamp.
                emit               = 1'b1;
                out_msg_next.stamp = q_rdata.stamp;
                if (msg_open_reg && (open_stamp_reg < q_rdata.stamp))
                begin
                    open_stamp_next = q_rdata.stamp;
                end
            end
            else
            begin
                msg_open_next   = 1'b1;
                open_stamp_next = mts;
                if (q_rdata.kind == mbsp_pkg::KIND_STATUS)
                begin
                    // New status byte.
                    running_stat_next = q_rdata.rx_byte;
                    await_third_next  = 1'b0;
                    if (q_rdata.solo)
                    begin
                        emit          = 1'b1;
                        msg_open_next = 1'b0;
                    end
                end
                else if (await_third_reg)
                begin
                    // Third byte completes a held message.
                    emit                = 1'b1;
                    await_third_next    = 1'b0;
                    msg_open_next       = 1'b0;
                    out_msg_next.status = held_status_reg;
                    out_msg_next.data1  = held_data1_reg;
                    out_msg_next.data2  = q_rdata.rx_byte[6:0];
                    out_msg_next.length = mbsp_pkg::LEN_THREE;
                end
                else if (running_stat_reg != '0)
                begin
                    // Data byte under running status.
                    out_msg_next.status = running_stat_reg;
                    out_msg_next.data1  = q_rdata.rx_byte[6:0];
                    out_msg_next.length = mbsp_pkg::LEN_TWO;
                    if (rs_hi inside {mbsp_pkg::HI_NOTE_OFF, mbsp_pkg::HI_NOTE_ON,
                                      mbsp_pkg::HI_POLY_PRESS, mbsp_pkg::HI_CTRL_CHANGE,
                                      mbsp_pkg::HI_PITCH_BEND})
                    begin
                        await_third_next = 1'b1;
                        held_status_next = running_stat_reg;
                        held_data1_next  = q_rdata.rx_byte[6:0];
                    end
                    else if (rs_hi inside {mbsp_pkg::HI_PROG_CHANGE,
                                           mbsp_pkg::HI_CHAN_PRESS})
                    begin
                        emit          = 1'b1;
                        msg_open_next = 1'b0;
                    end
                    else
                    begin
                        // System common: running status ends here.
                        running_stat_next = '0;
                        if (running_stat_reg == mbsp_pkg::ST_SONG_POS)
                        begin
                            await_third_next = 1'b1;
                            held_status_next = running_stat_reg;
                            held_data1_next  = q_rdata.rx_byte[6:0];
                        end
                        else if ((running_stat_reg == mbsp_pkg::ST_TIME_CODE)
                                 || (running_stat_reg == mbsp_pkg::ST_SONG_SEL))
                        begin
                            emit          = 1'b1;
                            msg_open_next = 1'b0;
                        end
                    end
                end
            end
        end
    end

    // Output register handshake.
    always_comb
    begin
        if (q_pop)
        begin
            out_valid_next = emit;
        end
        else if (msg_out.ready)
        begin
            out_valid_next = 1'b0;
        end
        else
        begin
            out_valid_next = out_valid_reg;
        end
    end

    // Parser state and output valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            running_stat_reg <= '0;
            await_third_reg  <= 1'b0;
            msg_open_reg     <= 1'b0;
            open_stamp_reg   <= '0;
            held_status_reg  <= '0;
            held_data1_reg   <= '0;
            out_valid_reg    <= 1'b0;
        end
        else
        begin
            running_stat_reg <= running_stat_next;
            await_third_reg  <= await_third_next;
            msg_open_reg     <= msg_open_next;
            open_stamp_reg   <= open_stamp_next;
            held_status_reg  <= held_status_next;
            held_data1_reg   <= held_data1_next;
            out_valid_reg    <= out_valid_next;
        end
    end

    // Message payload.
    always_ff @(posedge clk)
    begin
        if (q_pop && emit)
        begin
            out_msg_reg <= out_msg_next;
        end
    end

    assign msg_out.valid      = out_valid_reg;
    assign msg_out.msg_status = out_msg_reg.status;
    assign msg_out.msg_data1  = out_msg_reg.data1;
    assign msg_out.msg_data2  = out_msg_reg.data2;
    assign msg_out.msg_length = out_msg_reg.length;
    assign msg_out.msg_stamp  = out_msg_reg.stamp;

endmodule

`default_nettype wire

// ===== rtl/core/midi_byte_stream_parser.sv =====
// ============================================================================
// midi_byte_stream_parser
// MIDI byte parser with running status and real-time pass-through.
// ============================================================================
//
//   Channel    Dir   Item                          Handshake
//   byte_in    in    stamp[15:0], rx_byte[7:0]     valid / ready
//   msg_out    out   status, data1, data2,        valid / ready
//                    length, stamp
//
// One item per cycle sustained while msg_out is ready; a message is offered
// on msg_out once its last byte has been written into the queue slot at
// acceptance and then into the output register.
// The two-entry queue lets input keep flowing while msg_out is stalled,
// until the queue fills; the back part stops when its output register is full.
// Reset clears running status, the pending message and all valid flags.
// ----------------------------------------------------------------------------
`default_nettype none

module midi_byte_stream_parser (
    input  wire logic  clk,
    input  wire logic  rst_n,
    mbsp_byte_if.sink  byte_in,
    mbsp_msg_if.source msg_out
);

    logic             q_push;
    logic             q_pop;
    logic             q_full;
    logic             q_not_empty;
    mbsp_pkg::entry_t q_wdata;
    mbsp_pkg::entry_t q_rdata;

    mbsp_front u_front (
        .byte_in (byte_in),
        .q_full  (q_full),
        .q_wdata (q_wdata),
        .q_push  (q_push)
    );

    mbsp_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (q_push),
        .wdata     (q_wdata),
        .full      (q_full),
        .pop       (q_pop),
        .not_empty (q_not_empty),
        .rdata     (q_rdata)
    );

    mbsp_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .q_not_empty (q_not_empty),
        .q_rdata     (q_rdata),
        .q_pop       (q_pop),
        .msg_out     (msg_out)
    );

    // A valid message always carries one to three bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        msg_out.valid |-> (msg_out.msg_length != 2'd0))
        else $error("message with zero length");

    // Real-time messages are single bytes.
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg_out.valid && (msg_out.msg_status[7:3] == mbsp_pkg::RT_PREFIX))
        |-> (msg_out.msg_length == mbsp_pkg::LEN_ONE))
        else $error("real-time message longer than one byte");

    // Unused data bytes are zero.
    assert property (@(posedge clk) disable iff (!rst_n)
        (msg_out.valid && (msg_out.msg_length != mbsp_pkg::LEN_THREE))
        |-> (msg_out.msg_data2 == 7'd0))
        else $error("second data byte set on a short message");

    assert property (@(posedge clk) disable iff (!rst_n)
        (msg_out.valid && (msg_out.msg_length == mbsp_pkg::LEN_ONE))
        |-> (msg_out.msg_data1 == 7'd0))
        else $error("first data byte set on a one-byte message");

endmodule

`default_nettype wire
